/* hw/rtl/swmt_pkg.sv */
// Shared constants and types for the sliding-window mode tracker.
package swmt_pkg;

	localparam int WINDOW_MAX = 64;
	localparam int IDX_W = $clog2(WINDOW_MAX);
	localparam int CNT_W = 7;
	localparam int WORD_W = 128;
	localparam int WORD_BYTES = 16;

	// Mask that keeps the leading WORD_BYTES bytes of a packed word.
	localparam logic [WORD_W-1:0] WORD_MASK =
		~({WORD_W{1'b1}} >> (8 * WORD_BYTES));

	localparam logic [1:0] REG_WINDOW_LEN = 2'd0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_SCAN,
		ST_OUT
	} state_t;

	// Command broadcast from the controller to every cell.
	typedef struct packed {
		logic              clear;
		logic              evict;
		logic [WORD_W-1:0] evict_word;
		logic              add;
		logic [WORD_W-1:0] add_word;
		logic              scan;
	} cell_cmd_t;

	// Leader candidate passed down the chain during a scan.
	typedef struct packed {
		logic [CNT_W-1:0]  count;
		logic [WORD_W-1:0] word;
	} lead_t;

	// Status passed down the chain: hit for the new word, a free cell seen upstream.
	typedef struct packed {
		logic hit;
		logic free_seen;
	} chain_t;

endpackage

/* hw/rtl/swmt_cell.sv */
// One table entry: a word, its count, and a stage of the leader scan chain.
module swmt_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  swmt_pkg::cell_cmd_t  cmd,
	input  swmt_pkg::chain_t     chain_in,
	output swmt_pkg::chain_t     chain_out,
	input  swmt_pkg::lead_t      lead_in,
	output swmt_pkg::lead_t      lead_out
);

	logic [swmt_pkg::WORD_W-1:0] word_q;
	logic [swmt_pkg::CNT_W-1:0]  count_q;
	swmt_pkg::lead_t             lead_q;
	logic                        used;
	logic                        match_new;
	logic                        match_old;
	logic                        claim;
	logic                        better;

	assign used      = (count_q != '0);
	assign match_new = used && (word_q == cmd.add_word);
	assign match_old = used && (word_q == cmd.evict_word);

	// Claim this cell only when no cell holds the word and no lower free cell exists.
	assign claim = !used && !chain_in.free_seen;
	assign chain_out.hit       = chain_in.hit | match_new;
	assign chain_out.free_seen = chain_in.free_seen | !used;

	// Entry update; eviction and addition are separate cycles.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.evict) begin
			if (match_old)
				count_q <= count_q - 1'b1;
		end else if (cmd.add) begin
			if (match_new)
				count_q <= count_q + 1'b1;
			else if (claim && !cmd.scan)
				count_q <= 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add && !cmd.evict && claim && !cmd.scan)
			word_q <= cmd.add_word;
	end

	// Scan stage: keep the better of the incoming candidate and this entry.
	assign better = used && ((count_q > lead_in.count) ||
		(count_q == lead_in.count && word_q < lead_in.word));

	always_ff @(posedge clk) begin
		if (better) begin
			lead_q.count <= count_q;
			lead_q.word  <= word_q;
		end else begin
			lead_q <= lead_in;
		end
	end

	assign lead_out = lead_q;

endmodule

/* hw/rtl/sliding_window_mode_tracker.sv */
// Sliding-window mode tracker: ring of recent words, counting cell chain, APB config.
// From input accept to out_valid: three update steps (read oldest word, evict, add),
// then a scan while the leader ripples down the 64 cells, registered in each cell.
// The tracker takes no new item until the last result is taken, so a held result
// stalls the input. Reset: clears counts, ring pointers and window_len (to 1).
module sliding_window_mode_tracker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        restart,
	input  logic [63:0] word_hi,
	input  logic [63:0] word_lo,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] top_word_hi,
	output logic [63:0] top_word_lo,
	output logic [6:0]  top_count
);

	localparam int N = swmt_pkg::WINDOW_MAX;
	localparam int IW = swmt_pkg::IDX_W;

	logic [6:0] window_len_q;
	logic [swmt_pkg::WORD_W-1:0] ring_mem [N];
	logic [swmt_pkg::WORD_W-1:0] ring_rd_q;
	logic [swmt_pkg::WORD_W-1:0] new_word_q;
	logic [IW-1:0]  head_q;
	logic [IW:0]    fill_q;
	logic [IW:0]    len_eff;
	logic           do_evict_q;
	logic           restart_q;
	logic [IW:0]    scan_cnt_q;
	logic [1:0]     step_q;
	swmt_pkg::state_t state_q, state_d;
	swmt_pkg::cell_cmd_t cmd;
	swmt_pkg::chain_t chain [N+1];
	swmt_pkg::lead_t  lead [N+1];
	logic [swmt_pkg::WORD_W-1:0] res_word_q;
	logic [6:0]     res_count_q;
	logic [IW-1:0]  tail;

	// Register port.
	assign pready = 1'b1;
	assign prdata = (paddr == swmt_pkg::REG_WINDOW_LEN) ? {25'd0, window_len_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			window_len_q <= 7'd1;
		else if (psel && penable && pwrite && paddr == swmt_pkg::REG_WINDOW_LEN)
			window_len_q <= pwdata[6:0];
	end

	// Effective window length, clamped to 1..WINDOW_MAX.
	always_comb begin
		if (window_len_q == '0)
			len_eff = (IW+1)'(1);
		else if ({25'd0, window_len_q} > 32'(N))
			len_eff = (IW+1)'(N);
		else
			len_eff = (IW+1)'(window_len_q);
	end

	assign in_ready = (state_q == swmt_pkg::ST_IDLE);
	assign tail = head_q + fill_q[IW-1:0];

	// Sequencer: step 0 reads the oldest word (and clears on restart), 1 evicts, 2 adds and appends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= swmt_pkg::ST_IDLE;
			head_q     <= '0;
			fill_q     <= '0;
			step_q     <= '0;
			scan_cnt_q <= '0;
			do_evict_q <= 1'b0;
			restart_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				swmt_pkg::ST_IDLE: begin
					if (in_valid) begin
						restart_q <= restart;
						step_q    <= '0;
						if (restart) begin
							head_q <= '0;
							fill_q <= '0;
						end
					end
				end
				swmt_pkg::ST_UPDATE: begin
					step_q <= step_q + 1'b1;
					if (step_q == 2'd0) begin
						do_evict_q <= (fill_q >= len_eff) && (fill_q != '0);
					end else if (step_q == 2'd1) begin
						if (do_evict_q) begin
							head_q <= head_q + 1'b1;
							fill_q <= fill_q - 1'b1;
						end
					end else begin
						if (fill_q != (IW+1)'(N))
							fill_q <= fill_q + 1'b1;
						scan_cnt_q <= '0;
					end
				end
				swmt_pkg::ST_SCAN: scan_cnt_q <= scan_cnt_q + 1'b1;
				swmt_pkg::ST_OUT: ;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			swmt_pkg::ST_IDLE:   if (in_valid) state_d = swmt_pkg::ST_UPDATE;
			swmt_pkg::ST_UPDATE: if (step_q == 2'd2) state_d = swmt_pkg::ST_SCAN;
			swmt_pkg::ST_SCAN:   if (scan_cnt_q == (IW+1)'(N)) state_d = swmt_pkg::ST_OUT;
			swmt_pkg::ST_OUT:    if (out_ready) state_d = swmt_pkg::ST_IDLE;
			default:             state_d = swmt_pkg::ST_IDLE;
		endcase
	end

	// Captured new word and ring memory.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			new_word_q <= {word_hi, word_lo} & swmt_pkg::WORD_MASK;
		if (state_q == swmt_pkg::ST_UPDATE && step_q == 2'd2)
			ring_mem[tail] <= new_word_q;
		ring_rd_q <= ring_mem[head_q];
	end

	// Cell commands.
	always_comb begin
		cmd            = '0;
		cmd.clear      = (state_q == swmt_pkg::ST_UPDATE) && (step_q == 2'd0) && restart_q;
		cmd.evict      = (state_q == swmt_pkg::ST_UPDATE) && (step_q == 2'd1) && do_evict_q;
		cmd.evict_word = ring_rd_q;
		cmd.add        = (state_q == swmt_pkg::ST_UPDATE) && (step_q == 2'd2);
		cmd.add_word   = new_word_q;
		cmd.scan       = chain[N].hit;
	end

	assign chain[0] = '0;
	assign lead[0]  = '0;

	for (genvar g = 0; g < N; g++) begin : g_cell
		swmt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.chain_in (chain[g]),
			.chain_out(chain[g+1]),
			.lead_in  (lead[g]),
			.lead_out (lead[g+1])
		);
	end

	always_ff @(posedge clk) begin
		if (state_q == swmt_pkg::ST_SCAN && scan_cnt_q == (IW+1)'(N)) begin
			res_word_q  <= lead[N].word;
			res_count_q <= lead[N].count;
		end
	end

	assign out_valid   = (state_q == swmt_pkg::ST_OUT);
	assign top_word_hi = res_word_q[127:64];
	assign top_word_lo = res_word_q[63:0];
	assign top_count   = res_count_q;

endmodule
